// ----- src/bba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared field widths, types and codes of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BLOCK_W   = 12;
  localparam int CFG_W     = 13;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  typedef logic [BLOCK_W-1:0]   block_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_FULL        = 2'd1;
  localparam status_t ST_DOUBLE_FREE = 2'd2;
  localparam status_t ST_RANGE       = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam cfg_idx_t REG_TOTAL_BLOCKS     = 2'd0;
  localparam cfg_idx_t REG_FIRST_DATA_BLOCK = 2'd1;

  localparam cfg_t TOTAL_BLOCKS_RST     = 13'd4096;
  localparam cfg_t FIRST_DATA_BLOCK_RST = 13'd1;

endpackage

// ----- src/bba_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_if
// Request and response channels of the bitmap block allocator.
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic            valid;
  logic            ready;
  logic            kind;
  bba_pkg::block_t block;

  modport source (output valid, output kind, output block, input ready);
  modport sink   (input valid, input kind, input block, output ready);
endinterface

interface bba_rsp_if;
  logic             valid;
  logic             ready;
  bba_pkg::block_t  allocated_block;
  bba_pkg::status_t status;

  modport source (output valid, output allocated_block, output status, input ready);
  modport sink   (input valid, input allocated_block, input status, output ready);
endinterface

// ----- src/bitmap_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used-bit map held in one word-wide RAM.
// ----------------------------------------------------------------------------
// One request is in flight at a time. An allocate walks the bitmap RAM from
// word 0, one word a cycle through its single read port, up to the first
// free bit at or above first_data_block (at most ceil(limit / WORD_BITS)
// words, 128 by default); with no room below the block count it answers
// without a scan. A free passes a word/bit split and then a read-modify-write;
// an out-of-range free is answered without either. After reset the RAM is
// cleared one word a cycle, ceil(MAX_BLOCKS / WORD_BITS) words (128 by
// default), before the first request is taken; configuration writes are
// taken throughout.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  bba_pkg::cfg_idx_t cfg_index,
  input  bba_pkg::cfg_t     cfg_data,
  bba_req_if.sink           req,
  bba_rsp_if.source         rsp
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIW       = $clog2(WORD_BITS);
  localparam int LW        = $clog2(MAX_BLOCKS + 1);
  localparam int CW        = (LW > bba_pkg::CFG_W) ? LW : bba_pkg::CFG_W;
  localparam int BW        = CW + 1;
  localparam int RSH       = 16;
  localparam int RECIP     = (1 << RSH) / WORD_BITS;
  localparam int QW        = bba_pkg::BLOCK_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FDIV  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;

  logic [2:0]             state, state_next;
  logic [WAW-1:0]         clr_cnt;
  bba_pkg::cfg_t          total_blocks, first_data_block;
  logic [WAW-1:0]         scan_word;
  logic [BW-1:0]          base;
  bba_pkg::block_t        blk_q;
  logic [QW-1:0]          q_est;
  logic [WAW-1:0]         fr_word;
  logic [BIW-1:0]         fr_bit;
  logic [WORD_BITS-1:0]   rdata;
  logic                   out_valid;
  bba_pkg::block_t        out_block;
  bba_pkg::status_t       out_status;

  logic [WORD_BITS-1:0]   mem [MAP_WORDS];

  logic [BW-1:0]          tot_ext, lim, fdb, blk_ext;
  logic                   accept;
  logic [BW-1:0]          lo_off, hi_off, grant;
  logic [WORD_BITS-1:0]   elig;
  logic                   found;
  logic [BIW-1:0]         found_idx;
  logic                   last_word;
  logic [31:0]            q_mul;
  bba_pkg::block_t        prod, rem_raw, r_fix;
  logic                   rem_hi;
  logic [QW-1:0]          q_fix;
  logic [WAW-1:0]         rd_addr;
  logic                   mem_we;
  logic [WAW-1:0]         mem_wa;
  logic [WORD_BITS-1:0]   mem_wd;
  logic                   res_load;
  bba_pkg::block_t        res_block;
  bba_pkg::status_t       res_status;
  logic                   no_room, out_range;

  assign tot_ext   = BW'(total_blocks);
  assign lim       = (tot_ext > BW'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : tot_ext;
  assign fdb       = BW'(first_data_block);
  assign blk_ext   = BW'(req.block);
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign no_room   = (fdb >= lim);
  assign out_range = (blk_ext >= lim) || (blk_ext < fdb);

  // scan of one word: lanes between first_data_block and the block count
  always_comb begin
    lo_off = (fdb > base) ? (fdb - base) : '0;
    hi_off = (lim > base) ? (lim - base) : '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      elig[i] = (BW'(i) >= lo_off) && (BW'(i) < hi_off) && !rdata[i];
    end
    found     = 1'b0;
    found_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (elig[i]) begin
        found     = 1'b1;
        found_idx = BIW'(i);
      end
    end
    grant     = base + BW'(found_idx);
    last_word = (base + BW'(WORD_BITS)) >= lim;
  end

  // word and bit of a freed block: reciprocal estimate, one correction
  assign q_mul   = 32'(req.block) * 32'(RECIP);
  assign prod    = bba_pkg::BLOCK_W'(32'(q_est) * 32'(WORD_BITS));
  assign rem_raw = blk_q - prod;
  assign rem_hi  = rem_raw >= bba_pkg::BLOCK_W'(WORD_BITS);
  assign q_fix   = rem_hi ? (q_est + 1'b1) : q_est;
  assign r_fix   = rem_hi ? (rem_raw - bba_pkg::BLOCK_W'(WORD_BITS)) : rem_raw;

  always_comb begin
    unique case (state)
      S_SCAN:  rd_addr = scan_word + 1'b1;
      S_FDIV:  rd_addr = WAW'(q_fix);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
      end
      S_SCAN: begin
        mem_we = found;
        mem_wa = scan_word;
        mem_wd = rdata | (WORD_BITS'(1) << found_idx);
      end
      S_FREE: begin
        mem_we = rdata[fr_bit];
        mem_wa = fr_word;
        mem_wd = rdata & ~(WORD_BITS'(1) << fr_bit);
      end
      default: ;
    endcase
  end

  always_comb begin
    res_load   = 1'b0;
    res_block  = '0;
    res_status = bba_pkg::ST_OK;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == WAW'(MAP_WORDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (req.kind == bba_pkg::KIND_ALLOC) begin
            if (no_room) begin
              res_load   = 1'b1;
              res_status = bba_pkg::ST_FULL;
            end else begin
              state_next = S_SCAN;
            end
          end else begin
            if (out_range) begin
              res_load   = 1'b1;
              res_status = bba_pkg::ST_RANGE;
            end else begin
              state_next = S_FDIV;
            end
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          res_load   = 1'b1;
          res_block  = bba_pkg::BLOCK_W'(grant);
          state_next = S_IDLE;
        end else if (last_word) begin
          res_load   = 1'b1;
          res_status = bba_pkg::ST_FULL;
          state_next = S_IDLE;
        end
      end
      S_FDIV: begin
        state_next = S_FREE;
      end
      S_FREE: begin
        res_load   = 1'b1;
        res_status = rdata[fr_bit] ? bba_pkg::ST_OK : bba_pkg::ST_DOUBLE_FREE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_cnt          <= '0;
      total_blocks     <= bba_pkg::TOTAL_BLOCKS_RST;
      first_data_block <= bba_pkg::FIRST_DATA_BLOCK_RST;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          bba_pkg::REG_TOTAL_BLOCKS:     total_blocks     <= cfg_data;
          bba_pkg::REG_FIRST_DATA_BLOCK: first_data_block <= cfg_data;
          default: ;
        endcase
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_word <= '0;
      base      <= '0;
      blk_q     <= req.block;
      q_est     <= QW'(q_mul >> RSH);
    end else if (state == S_SCAN && !found && !last_word) begin
      scan_word <= scan_word + 1'b1;
      base      <= base + BW'(WORD_BITS);
    end
    if (state == S_FDIV) begin
      fr_word <= WAW'(q_fix);
      fr_bit  <= BIW'(r_fix);
    end
    if (res_load) begin
      out_block  <= res_block;
      out_status <= res_status;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.allocated_block = out_block;
  assign rsp.status          = out_status;

  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && found) |-> (grant >= fdb && grant < lim))
    else $error("granted block outside data range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || rsp.ready))
    else $error("result overwrites an untaken response");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid || state == S_SCAN || state == S_FDIV))
    else $error("accepted transaction neither answered nor in work");

  a_free_write_bit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE && mem_we) |-> (res_status == bba_pkg::ST_OK))
    else $error("free writes the bitmap on a failed free");

endmodule
